// ----- src/hsbp_pkg.sv -----
`timescale 1ns / 1ps

package hsbp_pkg;

  localparam int ACT_W      = 3;
  localparam int IDX_W      = 9;
  localparam int LEN_W      = 5;
  localparam int CODE_W     = 16;
  localparam int POS_W      = 13;
  localparam int ENTRY_W    = LEN_W + CODE_W;
  localparam int LEN_MAX    = 16;
  localparam int TAIL_BASE  = 17;
  localparam int CHUNK_W    = 2 * CODE_W;
  localparam int CHUNK_N_W  = 6;
  localparam int ACC_W      = CHUNK_W + 7;
  localparam int Q_DEPTH    = 2;
  localparam int LIMIT_W    = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_LIT = 3'd0,
    ACT_LOAD_POS = 3'd1,
    ACT_EMIT_LIT = 3'd2,
    ACT_EMIT_POS = 3'd3,
    ACT_EMIT_RAW = 3'd4
  } action_e;

  // bit string headed for the packer, right aligned
  typedef struct packed {
    logic [CHUNK_N_W-1:0] n;
    logic [CHUNK_W-1:0]   x;
  } chunk_t;

  function automatic logic [LEN_W-1:0] sat_len(logic [LEN_W-1:0] n);
    return (n > LEN_W'(LEN_MAX)) ? LEN_W'(LEN_MAX) : n;
  endfunction

  function automatic logic [CODE_W-1:0] len_mask(logic [LEN_W-1:0] n);
    logic [CODE_W:0] one_hot;
    one_hot = (CODE_W + 1)'(1) << n;
    return (n >= LEN_W'(LEN_MAX)) ? '1 : CODE_W'(one_hot - (CODE_W + 1)'(1));
  endfunction

endpackage

// ----- src/hsbp_if.sv -----
`timescale 1ns / 1ps

interface hsbp_in_if;
  import hsbp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic [IDX_W-1:0]     table_index;
  logic [LEN_W-1:0]     code_length;
  logic [CODE_W-1:0]    code_word;
  logic [IDX_W-1:0]     symbol;
  logic [POS_W-1:0]     position;
  logic [LEN_W-1:0]     bit_count;
  logic [CODE_W-1:0]    bit_value;

  modport source (
    output valid, action, table_index, code_length, code_word, symbol, position,
           bit_count, bit_value,
    input  ready
  );
  modport sink (
    input  valid, action, table_index, code_length, code_word, symbol, position,
           bit_count, bit_value,
    output ready
  );
endinterface

interface hsbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       unpackable;
  logic       last;

  modport source (output valid, out_byte, byte_valid, unpackable, last, input ready);
  modport sink   (input valid, out_byte, byte_valid, unpackable, last, output ready);
endinterface

// ----- src/hsbp_front.sv -----
`timescale 1ns / 1ps

module hsbp_front
  import hsbp_pkg::*;
#(
  parameter int LITERAL_SYMBOLS  = 510,
  parameter int POSITION_SYMBOLS = 14,
  parameter int POSITION_BITS    = 13
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hsbp_in_if.sink      in_i,
  output logic         push_valid_o,
  output chunk_t       push_data_o,
  input  logic         push_ready_i
);

  localparam int LitAw = $clog2(LITERAL_SYMBOLS);
  localparam int PosAw = (POSITION_SYMBOLS > 1) ? $clog2(POSITION_SYMBOLS) : 1;
  localparam logic [POS_W-1:0] PosMask =
      (POSITION_BITS >= POS_W) ? '1 : POS_W'((1 << POSITION_BITS) - 1);

  logic [ENTRY_W-1:0] lit_mem [LITERAL_SYMBOLS];
  logic [ENTRY_W-1:0] pos_mem [POSITION_SYMBOLS];
  logic [ENTRY_W-1:0] lit_rdata_q, pos_rdata_q;

  logic               s1_valid_q, s1_valid_d;
  logic               code_en_q, code_en_d;
  logic               code_pos_q, code_pos_d;
  logic [LEN_W-1:0]   tail_n_q, tail_n_d;
  logic [CODE_W-1:0]  tail_x_q, tail_x_d;

  logic               accept, push;
  logic               lit_we, pos_we, lit_re, pos_re;
  logic [ENTRY_W-1:0] wentry;
  logic [POS_W-1:0]   pos_m;
  logic [LEN_W-1:0]   blen;
  logic               sym_ok, blen_ok, idx_lit_ok, idx_pos_ok;

  assign push         = s1_valid_q && push_ready_i;
  assign in_i.ready   = !s1_valid_q || push_ready_i;
  assign accept       = in_i.valid && in_i.ready;
  assign wentry       = {in_i.code_length, in_i.code_word};
  assign pos_m        = in_i.position & PosMask;
  assign sym_ok       = 32'(in_i.symbol) < LITERAL_SYMBOLS;
  assign idx_lit_ok   = 32'(in_i.table_index) < LITERAL_SYMBOLS;
  assign idx_pos_ok   = 32'(in_i.table_index) < POSITION_SYMBOLS;
  assign blen_ok      = 32'(blen) < POSITION_SYMBOLS;

  always_comb begin
    blen = '0;
    for (int i = 0; i < POS_W; i++) begin
      if (pos_m[i]) begin
        blen = LEN_W'(i + 1);
      end
    end
  end

  always_comb begin
    lit_we     = 1'b0;
    pos_we     = 1'b0;
    lit_re     = 1'b0;
    pos_re     = 1'b0;
    s1_valid_d = push ? 1'b0 : s1_valid_q;
    code_en_d  = code_en_q;
    code_pos_d = code_pos_q;
    tail_n_d   = tail_n_q;
    tail_x_d   = tail_x_q;
    if (accept) begin
      case (action_e'(in_i.action))
        ACT_LOAD_LIT: begin
          lit_we = idx_lit_ok;
        end
        ACT_LOAD_POS: begin
          pos_we = idx_pos_ok;
        end
        ACT_EMIT_LIT: begin
          lit_re     = sym_ok;
          s1_valid_d = 1'b1;
          code_en_d  = sym_ok;
          code_pos_d = 1'b0;
          tail_n_d   = '0;
          tail_x_d   = '0;
        end
        ACT_EMIT_POS: begin
          pos_re     = blen_ok;
          s1_valid_d = 1'b1;
          code_en_d  = blen_ok;
          code_pos_d = 1'b1;
          if (blen > LEN_W'(1)) begin
            tail_n_d = blen - LEN_W'(1);
            tail_x_d = CODE_W'(pos_m) & (CODE_W'('1) >> (LEN_W'(TAIL_BASE) - blen));
          end else begin
            tail_n_d = '0;
            tail_x_d = '0;
          end
        end
        ACT_EMIT_RAW: begin
          s1_valid_d = 1'b1;
          code_en_d  = 1'b0;
          code_pos_d = 1'b0;
          tail_n_d   = sat_len(in_i.bit_count);
          tail_x_d   = in_i.bit_value & len_mask(sat_len(in_i.bit_count));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (lit_we) begin
      lit_mem[LitAw'(in_i.table_index)] <= wentry;
    end
    if (lit_re) begin
      lit_rdata_q <= lit_mem[LitAw'(in_i.symbol)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[PosAw'(in_i.table_index)] <= wentry;
    end
    if (pos_re) begin
      pos_rdata_q <= pos_mem[PosAw'(blen)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_en_q  <= code_en_d;
    code_pos_q <= code_pos_d;
    tail_n_q   <= tail_n_d;
    tail_x_q   <= tail_x_d;
  end

  // code part followed by tail bits, as one string
  logic [ENTRY_W-1:0] entry;
  logic [LEN_W-1:0]   code_n;
  logic [CODE_W-1:0]  code_x;

  always_comb begin
    entry  = code_pos_q ? pos_rdata_q : lit_rdata_q;
    code_n = code_en_q ? sat_len(entry[ENTRY_W-1:CODE_W]) : '0;
    code_x = entry[CODE_W-1:0] & len_mask(code_n);
    push_data_o.n = CHUNK_N_W'(code_n) + CHUNK_N_W'(tail_n_q);
    push_data_o.x = (CHUNK_W'(code_x) << tail_n_q) | CHUNK_W'(tail_x_q);
  end

  assign push_valid_o = s1_valid_q;

endmodule

// ----- src/hsbp_queue.sv -----
`timescale 1ns / 1ps

module hsbp_queue
  import hsbp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  input  chunk_t push_data_i,
  output logic   push_ready_o,
  output logic   pop_valid_o,
  output chunk_t pop_data_o,
  input  logic   pop_ready_i
);

  localparam int PtrW = $clog2(Q_DEPTH);
  localparam int CntW = $clog2(Q_DEPTH + 1);

  chunk_t            slots_q [Q_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign push_ready_o = count_q != CntW'(Q_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/hsbp_back.sv -----
`timescale 1ns / 1ps

module hsbp_back
  import hsbp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  input  logic               pop_valid_i,
  input  chunk_t             pop_data_i,
  output logic               pop_ready_o,
  hsbp_out_if.source         out_o
);

  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [CHUNK_N_W-1:0] nbits_q, nbits_d, rem;
  logic [LIMIT_W-1:0]   limit_q, count_q;
  logic                 ovf_q, ovf_d;
  logic                 ovalid_q, obyte_valid_q, ounpack_q, olast_q;
  logic [7:0]           obyte_q, cur_byte;
  logic                 slot_free, emit, take, room;
  logic [6:0]           held;

  assign slot_free   = !ovalid_q || out_o.ready;
  assign emit        = (nbits_q >= CHUNK_N_W'(8)) && slot_free;
  assign rem         = emit ? nbits_q - CHUNK_N_W'(8) : nbits_q;
  assign pop_ready_o = rem < CHUNK_N_W'(8);
  assign take        = pop_valid_i && pop_ready_o;
  assign cur_byte    = 8'(acc_q >> (nbits_q - CHUNK_N_W'(8)));
  assign held        = acc_q[6:0] & 7'((8'd1 << rem[2:0]) - 8'd1);
  assign room        = count_q < limit_q;

  always_comb begin
    acc_d   = acc_q;
    nbits_d = rem;
    if (take) begin
      acc_d   = (ACC_W'(held) << pop_data_i.n) | ACC_W'(pop_data_i.x);
      nbits_d = rem + pop_data_i.n;
    end
    ovf_d = ovf_q || (emit && !room);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nbits_q  <= '0;
      acc_q    <= '0;
      limit_q  <= '1;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      nbits_q <= nbits_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (emit && room) begin
        count_q <= count_q + LIMIT_W'(1);
      end
      if (slot_free) begin
        ovalid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      obyte_q       <= room ? cur_byte : 8'd0;
      obyte_valid_q <= room;
      ounpack_q     <= ovf_d;
      olast_q       <= rem < CHUNK_N_W'(8);
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.out_byte   = obyte_q;
  assign out_o.byte_valid = obyte_valid_q;
  assign out_o.unpackable = ounpack_q;
  assign out_o.last       = olast_q;

endmodule

// ----- src/huffman_symbol_bit_packer_core.sv -----
`timescale 1ns / 1ps

// Huffman symbol bit packer. The front takes one transaction per cycle unless
// its stage holds an item that the full queue cannot take: table loads finish
// there, emit items read the code table (one registered read) and hand a
// right-aligned bit string of up to 32 bits to a two-entry queue. The back packs
// strings MSB first and sends one byte per cycle through its output register
// while the receiver is ready: literal and raw items complete up to 2 bytes,
// position items up to 4. Bytes at or beyond byte_limit come out with byte_valid
// low and set unpackable. Flush with a raw emit of 7 zero bits.
module huffman_symbol_bit_packer_core
  import hsbp_pkg::*;
#(
  parameter int LITERAL_SYMBOLS  = 510,
  parameter int POSITION_SYMBOLS = 14,
  parameter int POSITION_BITS    = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  hsbp_in_if.sink            in_i,
  hsbp_out_if.source         out_o
);

  logic   push_valid, push_ready, pop_valid, pop_ready;
  chunk_t push_data, pop_data;

  hsbp_front #(
    .LITERAL_SYMBOLS  (LITERAL_SYMBOLS),
    .POSITION_SYMBOLS (POSITION_SYMBOLS),
    .POSITION_BITS    (POSITION_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  hsbp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  hsbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import hsbp_pkg::*;

  localparam int LIT_SYMS      = 510;
  localparam int POS_SYMS      = 14;
  localparam int POS_BITS      = 13;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 12;
  localparam int MAX_BYTES     = 4;
  localparam logic [ACT_W-1:0] ACT_RSVD_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD_LAST  = 3'd7;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  table_index;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_word;
    logic [IDX_W-1:0]  symbol;
    logic [POS_W-1:0]  position;
    logic [LEN_W-1:0]  bit_count;
    logic [CODE_W-1:0] bit_value;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       unp;
    logic       last;
  } byte_res_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [LIMIT_W-1:0] cfg_wdata_i;

  hsbp_in_if  in_if ();
  hsbp_out_if out_if ();

  huffman_symbol_bit_packer_core #(
    .LITERAL_SYMBOLS (LIT_SYMS),
    .POSITION_SYMBOLS(POS_SYMS),
    .POSITION_BITS   (POS_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // packer model state
  logic [ENTRY_W-1:0] lit_codes_m [LIT_SYMS];
  logic [ENTRY_W-1:0] pos_codes_m [POS_SYMS];
  logic [7:0]         part_byte;
  int unsigned        free_slots;
  logic [31:0]        bytes_sent;
  logic               ovf;
  logic [31:0]        byte_limit_m;

  byte_res_t   step_bytes[$];
  byte_res_t   exp_bytes[$];
  item_t       pend_items[$];
  item_t       on_bus;
  int          lit_loaded[$];
  bit          pos_loaded [POS_SYMS];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          err_count;
  int          stall_cycles;

  task automatic report(input string msg);
    err_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic push_byte(input logic [7:0] b);
    byte_res_t r;
    if (step_bytes.size() >= MAX_BYTES) return;
    if (bytes_sent < byte_limit_m) begin
      bytes_sent++;
      r.data = b;
      r.vld  = 1'b1;
    end else begin
      ovf    = 1'b1;
      r.data = 8'h00;
      r.vld  = 1'b0;
    end
    r.unp  = ovf;
    r.last = 1'b0;
    step_bytes.push_back(r);
  endtask

  task automatic put_bits(input int unsigned n, input logic [31:0] x);
    int unsigned held;
    int unsigned nbits;
    logic [63:0] acc;
    if (n > LEN_MAX) n = LEN_MAX;
    x &= (32'd1 << n) - 32'd1;
    held  = 8 - free_slots;
    acc   = ((64'(part_byte) >> free_slots) << n) | 64'(x);
    nbits = held + n;
    while (nbits >= 8) begin
      push_byte(8'(acc >> (nbits - 8)));
      nbits -= 8;
    end
    acc &= (64'd1 << nbits) - 64'd1;
    part_byte  = 8'(acc << (8 - nbits));
    free_slots = 8 - nbits;
  endtask

  task automatic put_entry(input logic [ENTRY_W-1:0] e);
    put_bits(32'(e[ENTRY_W-1:CODE_W]), 32'(e[CODE_W-1:0]));
  endtask

  task automatic pack_item(input item_t it);
    int unsigned c;
    logic [POS_W-1:0] q;
    step_bytes.delete();
    case (it.action)
      ACT_LOAD_LIT: if (it.table_index < LIT_SYMS)
        lit_codes_m[it.table_index] = {it.code_length, it.code_word};
      ACT_LOAD_POS: if (it.table_index < POS_SYMS)
        pos_codes_m[it.table_index] = {it.code_length, it.code_word};
      ACT_EMIT_LIT: if (it.symbol < LIT_SYMS) put_entry(lit_codes_m[it.symbol]);
      ACT_EMIT_POS: begin
        c = 0;
        for (q = it.position; q != 0; q >>= 1) c++;
        if (c < POS_SYMS) put_entry(pos_codes_m[c]);
        if (c > 1) put_bits(c - 1, 32'(it.position) & (32'hFFFF >> (TAIL_BASE - c)));
      end
      ACT_EMIT_RAW: put_bits(32'(it.bit_count), 32'(it.bit_value));
      default: ;
    endcase
    if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].last = 1'b1;
    foreach (step_bytes[i]) exp_bytes.push_back(step_bytes[i]);
  endtask

  // a, b, w feed index/symbol/position, length/count, word/value
  function automatic item_t make_item(logic [ACT_W-1:0] act, int a, int b, int w);
    item_t it;
    it.action      = act;
    it.table_index = IDX_W'(a);
    it.symbol      = IDX_W'(a);
    it.position    = POS_W'(a);
    it.code_length = LEN_W'(b);
    it.bit_count   = LEN_W'(b);
    it.code_word   = CODE_W'(w);
    it.bit_value   = CODE_W'(w);
    return it;
  endfunction

  task automatic queue_item(input item_t it);
    if (it.action == ACT_LOAD_LIT && it.table_index < LIT_SYMS)
      lit_loaded.push_back(int'(it.table_index));
    if (it.action == ACT_LOAD_POS && it.table_index < POS_SYMS)
      pos_loaded[it.table_index] = 1'b1;
    pend_items.push_back(it);
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r == 1) return LEN_W'($urandom_range(31, LEN_MAX + 1));
    return LEN_W'($urandom_range(LEN_MAX, 1));
  endfunction

  task automatic queue_random(input int count);
    item_t it;
    int n;
    int sel;
    int c;
    n = 0;
    while (n < count) begin
      it.table_index = IDX_W'($urandom_range(511));
      it.code_length = LEN_W'($urandom_range(31));
      it.code_word   = CODE_W'($urandom_range(16'hFFFF));
      it.symbol      = IDX_W'($urandom_range(511));
      it.position    = POS_W'($urandom_range(8191));
      it.bit_count   = LEN_W'($urandom_range(31));
      it.bit_value   = CODE_W'($urandom_range(16'hFFFF));
      sel = $urandom_range(99);
      if (sel < 14) begin
        it.action      = ACT_LOAD_LIT;
        it.table_index = ($urandom_range(19) == 0) ? IDX_W'(LIT_SYMS + $urandom_range(1))
                                                   : IDX_W'($urandom_range(LIT_SYMS - 1));
        it.code_length = pick_len();
      end else if (sel < 22) begin
        it.action      = ACT_LOAD_POS;
        it.table_index = ($urandom_range(7) == 0) ? IDX_W'($urandom_range(511, POS_SYMS))
                                                  : IDX_W'($urandom_range(POS_SYMS - 1));
        it.code_length = pick_len();
      end else if (sel < 55) begin
        it.action = ACT_EMIT_LIT;
        if (lit_loaded.size() == 0 || $urandom_range(19) == 0)
          it.symbol = IDX_W'(LIT_SYMS + $urandom_range(1));
        else
          it.symbol = IDX_W'(lit_loaded[$urandom_range(lit_loaded.size() - 1)]);
      end else if (sel < 77) begin
        it.action = ACT_EMIT_POS;
        do c = $urandom_range(POS_BITS); while (!pos_loaded[c]);
        it.position = (c == 0) ? '0
                    : POS_W'((1 << (c - 1)) | ($urandom & ((1 << (c - 1)) - 1)));
      end else if (sel < 97) begin
        it.action    = ACT_EMIT_RAW;
        it.bit_count = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(31))
                                                : LEN_W'($urandom_range(LEN_MAX));
      end else begin
        it.action = ACT_W'($urandom_range(ACT_RSVD_LAST, ACT_RSVD_FIRST));
      end
      queue_item(it);
      if (it.action < ACT_RSVD_FIRST) n++;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pend_items.size() != 0 || in_if.valid || exp_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    byte_limit_m = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) pack_item(on_bus);
      if (!in_if.valid || in_if.ready) begin
        if (pend_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pend_items.pop_front();
          in_if.valid       <= 1'b1;
          in_if.action      <= on_bus.action;
          in_if.table_index <= on_bus.table_index;
          in_if.code_length <= on_bus.code_length;
          in_if.code_word   <= on_bus.code_word;
          in_if.symbol      <= on_bus.symbol;
          in_if.position    <= on_bus.position;
          in_if.bit_count   <= on_bus.bit_count;
          in_if.bit_value   <= on_bus.bit_value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    byte_res_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (exp_bytes.size() == 0) begin
          report($sformatf("unexpected transaction, byte %02h", out_if.out_byte));
        end else begin
          want = exp_bytes.pop_front();
          if (out_if.out_byte !== want.data)
            report($sformatf("out_byte %02h, expected %02h", out_if.out_byte, want.data));
          if (out_if.byte_valid !== want.vld)
            report($sformatf("byte_valid %b, expected %b", out_if.byte_valid, want.vld));
          if (out_if.unpackable !== want.unp)
            report($sformatf("unpackable %b, expected %b", out_if.unpackable, want.unp));
          if (out_if.last !== want.last)
            report($sformatf("last %b, expected %b", out_if.last, want.last));
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_if.valid       = 1'b0;
    in_if.action      = '0;
    in_if.table_index = '0;
    in_if.code_length = '0;
    in_if.code_word   = '0;
    in_if.symbol      = '0;
    in_if.position    = '0;
    in_if.bit_count   = '0;
    in_if.bit_value   = '0;
    out_if.ready      = 1'b0;
    err_count         = 0;
    stall_cycles      = 0;
    part_byte         = '0;
    free_slots        = 8;
    bytes_sent        = '0;
    ovf               = 1'b0;
    byte_limit_m      = '1;
    foreach (lit_codes_m[i]) lit_codes_m[i] = '0;
    foreach (pos_codes_m[i]) pos_codes_m[i] = '0;
    foreach (pos_loaded[i]) pos_loaded[i] = 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 71;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_limit(32'hFFFF_FFFF);

    // table loads: full length, saturated length, masked word, empty code, out of range
    queue_item(make_item(ACT_LOAD_LIT, 0, 16, 16'hFFFF));
    queue_item(make_item(ACT_LOAD_LIT, 509, 31, 16'hA5C3));
    queue_item(make_item(ACT_LOAD_LIT, 1, 3, 16'hFFFF));
    queue_item(make_item(ACT_LOAD_LIT, 2, 0, 16'h1234));
    queue_item(make_item(ACT_LOAD_LIT, 511, 5, 16'h0003));
    queue_item(make_item(ACT_LOAD_POS, 0, 1, 16'h0000));
    queue_item(make_item(ACT_LOAD_POS, 1, 2, 16'h0002));
    queue_item(make_item(ACT_LOAD_POS, 2, 5, 16'h001F));
    queue_item(make_item(ACT_LOAD_POS, 13, 17, 16'hBEEF));
    queue_item(make_item(ACT_LOAD_POS, 14, 4, 16'h0005));
    // emits
    queue_item(make_item(ACT_EMIT_LIT, 0, 0, 0));
    queue_item(make_item(ACT_EMIT_LIT, 509, 0, 0));
    queue_item(make_item(ACT_EMIT_LIT, 1, 0, 0));
    queue_item(make_item(ACT_EMIT_LIT, 2, 0, 0));
    queue_item(make_item(ACT_EMIT_LIT, 510, 0, 0));
    queue_item(make_item(ACT_EMIT_LIT, 511, 0, 0));
    queue_item(make_item(ACT_EMIT_POS, 0, 0, 0));
    queue_item(make_item(ACT_EMIT_POS, 1, 0, 0));
    queue_item(make_item(ACT_EMIT_POS, 8191, 0, 0));
    queue_item(make_item(ACT_EMIT_POS, 4096, 0, 0));
    queue_item(make_item(ACT_EMIT_POS, 2, 0, 0));
    queue_item(make_item(ACT_EMIT_RAW, 0, 0, 16'hFFFF));
    queue_item(make_item(ACT_EMIT_RAW, 0, 16, 16'hFFFF));
    queue_item(make_item(ACT_EMIT_RAW, 0, 31, 16'h5A5A));
    queue_item(make_item(ACT_RSVD_FIRST, 3, 16, 16'hFFFF));
    queue_item(make_item(ACT_RSVD_LAST, 3, 16, 16'hFFFF));
    queue_item(make_item(ACT_EMIT_RAW, 0, 7, 0));
    wait_idle();

    queue_random(40);
    wait_idle();

    send_idle_pct = 71;
    recv_idle_pct = 27;
    write_limit(bytes_sent + 32'd24);
    queue_random(40);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(32'h0000_0000);
    queue_random(15);
    wait_idle();

    write_limit(32'hFFFF_FFFF);
    queue_random(35);
    queue_item(make_item(ACT_EMIT_RAW, 0, 7, 0));
    wait_idle();

    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
